// ----- src/stld_pkg.sv -----
package stld_pkg;

   typedef enum logic [1:0] {
      OP_REPLACE = 2'd0,
      OP_OR      = 2'd1,
      OP_XOR     = 2'd2,
      OP_RSVD    = 2'd3
   } combine_type;

   localparam logic [2:0] REG_PEN_COLOR  = 3'd0;
   localparam logic [2:0] REG_PEN_WEIGHT = 3'd1;
   localparam logic [2:0] REG_COMBINE    = 3'd2;
   localparam logic [2:0] REG_DASH_ON0   = 3'd3;
   localparam logic [2:0] REG_DASH_OFF0  = 3'd4;
   localparam logic [2:0] REG_DASH_ON1   = 3'd5;
   localparam logic [2:0] REG_DASH_OFF1  = 3'd6;
   localparam logic [2:0] REG_DASH_START = 3'd7;

   localparam int COORD_W  = 9;
   localparam int PEL_W    = 3;
   localparam int RUN_W    = 6;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 6;

   // Settings the drawing engine needs for one line.
   typedef struct packed {
      logic [PEL_W-1:0] color;
      logic             wide;
      combine_type      op;
      logic [RUN_W-1:0] len0;
      logic [RUN_W-1:0] len1;
      logic [RUN_W-1:0] len2;
      logic [RUN_W-1:0] len3;
      logic [1:0]       run0;
      logic [3:0]       ovr;
   } pen_type;

   function automatic logic [PEL_W-1:0] combine_pel(combine_type op,
                                                    logic [PEL_W-1:0] prev,
                                                    logic [PEL_W-1:0] color);
      logic [PEL_W-1:0] r;
      case (op)
         OP_OR:   r = prev | color;
         OP_XOR:  r = prev ^ color;
         default: r = color;
      endcase
      return r;
   endfunction

endpackage

// ----- src/styled_thick_line_draw_unit.sv -----
// Channel | Direction | Ports
// req     | in        | req_valid/req_ready, mode, start/end x/y, use_dash
// rsp     | out       | rsp_valid/rsp_ready, read_value, draw_done
// csr     | in        | csr_valid/csr_ready, csr_index, csr_data
// After reset the store is cleared one pel a cycle, all PLANE_WIDTH*PLANE_HEIGHT
// pels (138240 at the default size), while no request is taken.
// A read request passes RD_ADDR, RD_WAIT, RD_DONE and RESP to the output register.
// A draw request stamps each pel through the address, read-wait and write-back
// states; a clipped pel skips the write-back. Each step passes the STEP and DASH
// states, and DASH waits at the line start and while empty dash runs are skipped.
// A finished result waits in an output register; a stalled rsp holds the engine.
module styled_thick_line_draw_unit #(
   parameter int PLANE_WIDTH  = 480,
   parameter int PLANE_HEIGHT = 288
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [8:0] req_start_x,
   input  logic [8:0] req_start_y,
   input  logic [8:0] req_end_x,
   input  logic [8:0] req_end_y,
   input  logic       req_use_dash,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_read_value,
   output logic       rsp_draw_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_index,
   input  logic [5:0] csr_data
);

   localparam int DEPTH  = PLANE_WIDTH * PLANE_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD_ADDR, ST_RD_WAIT, ST_RD_DONE,
      ST_DASH, ST_STAMP, ST_PEL_WAIT, ST_PEL_WRITE, ST_STEP, ST_RESP
   } state_type;

   state_type state_ff;

   stld_pkg::pen_type pen_ff;

   // Registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff.color <= 3'd7;
         pen_ff.wide  <= 1'b0;
         pen_ff.op    <= stld_pkg::OP_REPLACE;
         pen_ff.len0  <= '0;
         pen_ff.len1  <= '0;
         pen_ff.len2  <= '0;
         pen_ff.len3  <= '0;
         pen_ff.run0  <= '0;
         pen_ff.ovr   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            {1'b0, stld_pkg::REG_PEN_COLOR}:  pen_ff.color <= csr_data[2:0];
            {1'b0, stld_pkg::REG_PEN_WEIGHT}: pen_ff.wide  <= csr_data[1];
            {1'b0, stld_pkg::REG_COMBINE}:
               pen_ff.op <= stld_pkg::combine_type'(csr_data[1:0]);
            {1'b0, stld_pkg::REG_DASH_ON0}:   pen_ff.len0 <= csr_data;
            {1'b0, stld_pkg::REG_DASH_OFF0}:  pen_ff.len1 <= csr_data;
            {1'b0, stld_pkg::REG_DASH_ON1}:   pen_ff.len2 <= csr_data;
            {1'b0, stld_pkg::REG_DASH_OFF1}:  pen_ff.len3 <= csr_data;
            {1'b0, stld_pkg::REG_DASH_START}: begin
               pen_ff.run0 <= csr_data[5:4];
               pen_ff.ovr  <= csr_data[3:0];
            end
            default: ;
         endcase
      end
   end

   // Line state.
   logic [9:0]  x_ff, y_ff, ex_ff, ey_ff;
   logic signed [11:0] err_ff, dx_ff, dy_ff;
   logic        sxn_ff, syn_ff, styled_ff, mode_ff;
   logic [1:0]  sub_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W:0]   clr_ff;
   logic [2:0]  rv_ff;
   logic        rsp_valid_ff, rsp_done_ff;
   logic [2:0]  rsp_val_ff;

   logic        wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [2:0]  wr_data;
   logic [2:0]  rd_data;

   logic        dash_load, dash_adv, dash_busy, dash_vis;
   logic        resp_load;

   stld_dash u_dash (
      .clock   (clock),
      .reset   (reset),
      .load    (dash_load),
      .advance (dash_adv),
      .pen     (pen_ff),
      .busy    (dash_busy),
      .visible (dash_vis)
   );

   stld_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   logic solid;
   assign solid = ({2'b00, pen_ff.len0} + {2'b00, pen_ff.len1} + {2'b00, pen_ff.len2}
                   + {2'b00, pen_ff.len3}) == 8'd0 || !styled_ff;

   // Current stamp pel.
   logic [9:0] px, py;
   logic       pin;
   assign px  = x_ff + {9'd0, sub_ff[0]};
   assign py  = y_ff + {9'd0, sub_ff[1]};
   assign pin = ({1'b0, px} < 11'(PLANE_WIDTH)) && ({1'b0, py} < 11'(PLANE_HEIGHT));

   logic [ADDR_W-1:0] paddr;
   assign paddr = ADDR_W'(int'(py) * PLANE_WIDTH + int'(px));

   logic signed [11:0] e2;
   assign e2 = err_ff <<< 1;
   logic last_pt;
   assign last_pt = (x_ff == ex_ff) && (y_ff == ey_ff);

   assign wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_PEL_WRITE);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff[ADDR_W-1:0] : addr_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? 3'd0
                  : stld_pkg::combine_pel(pen_ff.op, rd_data, pen_ff.color);

   assign dash_load = (state_ff == ST_IDLE) && req_valid && !req_mode;
   assign dash_adv  = (state_ff == ST_STEP) && !last_pt;
   assign req_ready = (state_ff == ST_IDLE);
   assign resp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   logic [9:0] dxa, dya;
   assign dxa = (req_end_x > req_start_x) ? {1'b0, req_end_x - req_start_x}
                                          : {1'b0, req_start_x - req_end_x};
   assign dya = (req_end_y > req_start_y) ? {1'b0, req_end_y - req_start_y}
                                          : {1'b0, req_start_y - req_end_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (resp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + {{ADDR_W{1'b0}}, 1'b1};
               if (clr_ff == (ADDR_W + 1)'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff   <= req_mode;
                  x_ff      <= {1'b0, req_start_x};
                  y_ff      <= {1'b0, req_start_y};
                  ex_ff     <= {1'b0, req_end_x};
                  ey_ff     <= {1'b0, req_end_y};
                  styled_ff <= req_use_dash;
                  dx_ff     <= {2'b00, dxa};
                  dy_ff     <= -$signed({2'b00, dya});
                  err_ff    <= $signed({2'b00, dxa}) - $signed({2'b00, dya});
                  sxn_ff    <= !(req_start_x < req_end_x);
                  syn_ff    <= !(req_start_y < req_end_y);
                  sub_ff    <= 2'd0;
                  state_ff  <= req_mode ? ST_RD_ADDR : ST_DASH;
               end
            end
            ST_RD_ADDR: begin
               addr_ff  <= paddr;
               state_ff <= ST_RD_WAIT;
            end
            ST_RD_WAIT: state_ff <= ST_RD_DONE;
            ST_RD_DONE: begin
               rv_ff    <= pin ? rd_data : 3'd0;
               state_ff <= ST_RESP;
            end
            ST_DASH: begin
               if (solid || !dash_busy) begin
                  sub_ff   <= 2'd0;
                  state_ff <= (solid || dash_vis) ? ST_STAMP : ST_STEP;
               end
            end
            ST_STAMP: begin
               addr_ff  <= paddr;
               state_ff <= ST_PEL_WAIT;
            end
            ST_PEL_WAIT: begin
               if (pin) begin
                  state_ff <= ST_PEL_WRITE;
               end else if (pen_ff.wide && sub_ff != 2'd3) begin
                  // A clipped pel of a wide stamp still walks the remaining corners.
                  sub_ff   <= sub_ff + 2'd1;
                  state_ff <= ST_STAMP;
               end else begin
                  state_ff <= ST_STEP;
               end
            end
            ST_PEL_WRITE: begin
               if (pen_ff.wide && sub_ff != 2'd3) begin
                  sub_ff   <= sub_ff + 2'd1;
                  state_ff <= ST_STAMP;
               end else begin
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (last_pt) begin
                  rv_ff    <= 3'd0;
                  state_ff <= ST_RESP;
               end else begin
                  if (e2 >= dy_ff) begin
                     err_ff <= err_ff + dy_ff + ((e2 <= dx_ff) ? dx_ff : 12'sd0);
                     x_ff   <= sxn_ff ? x_ff - 10'd1 : x_ff + 10'd1;
                  end else if (e2 <= dx_ff) begin
                     err_ff <= err_ff + dx_ff;
                  end
                  if (e2 <= dx_ff) begin
                     y_ff <= syn_ff ? y_ff - 10'd1 : y_ff + 10'd1;
                  end
                  state_ff <= ST_DASH;
               end
            end
            ST_RESP: begin
               if (resp_load) begin
                  rsp_val_ff   <= rv_ff;
                  rsp_done_ff  <= !mode_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_val_ff;
   assign rsp_draw_done  = rsp_done_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request taken during store clear");
   a_write_only_in_pass: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_PEL_WRITE))
      else $error("store written outside clear or pel write");
   a_rsp_after_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_RESP)
      else $error("response raised outside response state");

endmodule

// ----- src/stld_ram.sv -----
module stld_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/stld_dash.sv -----
// Tracks the dash run that the current step falls in, one step per advance.
module stld_dash (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              advance,
   input  stld_pkg::pen_type pen,
   output logic              busy,
   output logic              visible
);

   logic [1:0]  run_ff, run_in;
   logic [6:0]  left_ff, left_in;
   logic        busy_ff, busy_in;
   logic        first_ff, first_in;
   logic [5:0]  len_sel;
   logic [1:0]  nrun;
   logic [5:0]  nlen;

   always_comb begin
      case (run_ff)
         2'd0:    len_sel = pen.len0;
         2'd1:    len_sel = pen.len1;
         2'd2:    len_sel = pen.len2;
         default: len_sel = pen.len3;
      endcase
      nrun = run_ff + 2'd1;
      case (nrun)
         2'd0:    nlen = pen.len0;
         2'd1:    nlen = pen.len1;
         2'd2:    nlen = pen.len2;
         default: nlen = pen.len3;
      endcase
   end

   always_comb begin
      run_in   = run_ff;
      left_in  = left_ff;
      busy_in  = busy_ff;
      first_in = first_ff;
      if (load) begin
         run_in   = pen.run0;
         busy_in  = 1'b1;
         left_in  = 7'd0;
         first_in = 1'b1;
      end else if (busy_ff) begin
         // Skip exhausted runs, one per cycle, until a live run is found.
         if (left_ff == 7'd0) begin
            first_in = 1'b0;
            if (first_ff && pen.ovr != 4'd0) begin
               // The override applies only to the starting run.
               left_in = {3'd0, pen.ovr};
               busy_in = 1'b0;
            end else begin
               left_in = {1'b0, len_sel};
               if (len_sel == 6'd0) begin
                  run_in = nrun;
               end else begin
                  busy_in = 1'b0;
               end
            end
         end
      end else if (advance) begin
         if (left_ff == 7'd1) begin
            run_in  = nrun;
            left_in = {1'b0, nlen};
            busy_in = (nlen == 6'd0);
         end else begin
            left_in = left_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         run_ff   <= 2'd0;
         left_ff  <= 7'd0;
         first_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         run_ff   <= run_in;
         left_ff  <= left_in;
         first_ff <= first_in;
      end
   end

   assign busy    = busy_ff;
   assign visible = ~run_ff[0];

endmodule

// ----- tb/tb_styled_thick_line_draw_unit.sv -----
`timescale 1ns / 1ps

module tb_styled_thick_line_draw_unit;

   localparam int PW = 480;
   localparam int PH = 288;
   localparam int STALL_LIMIT = 1000000;

   // Mirror of the engine: its own frame store, pen settings and the order of
   // the results it still owes.
   class line_scoreboard;
      bit [2:0]    pels[PW*PH];
      bit [2:0]    color = 3'd7;
      bit [1:0]    weight = 2'd1;
      stld_pkg::combine_type op = stld_pkg::OP_REPLACE;
      bit [5:0]    run_len[4];
      bit [5:0]    start_cfg;
      bit [2:0]    want_value[$];
      bit          want_done[$];
      int          errors;

      function void write_reg(bit [3:0] idx, bit [5:0] data);
         case (idx)
            4'(stld_pkg::REG_PEN_COLOR):  color = data[2:0];
            4'(stld_pkg::REG_PEN_WEIGHT): weight = data[1:0];
            4'(stld_pkg::REG_COMBINE):    op = stld_pkg::combine_type'(data[1:0]);
            4'(stld_pkg::REG_DASH_ON0):   run_len[0] = data;
            4'(stld_pkg::REG_DASH_OFF0):  run_len[1] = data;
            4'(stld_pkg::REG_DASH_ON1):   run_len[2] = data;
            4'(stld_pkg::REG_DASH_OFF1):  run_len[3] = data;
            4'(stld_pkg::REG_DASH_START): start_cfg = data;
            default: ;
         endcase
      endfunction

      function bit step_visible(int along);
         int  rem;
         int  pos;
         int  period;
         bit [1:0] run;
         period = run_len[0] + run_len[1] + run_len[2] + run_len[3];
         if (period == 0) return 1'b1;
         pos = along;
         run = start_cfg[5:4];
         rem = (start_cfg[3:0] != 0) ? start_cfg[3:0] : run_len[run];
         for (int g = 0; g < 4096; g++) begin
            if (rem > 0) begin
               if (pos < rem) return ~run[0];
               pos -= rem;
            end
            run = run + 2'd1;
            rem = run_len[run];
         end
         return 1'b1;
      endfunction

      function void stamp(int x, int y);
         int       idx;
         bit [2:0] prev;
         if (x < 0 || x >= PW || y < 0 || y >= PH) return;
         idx = y * PW + x;
         prev = pels[idx];
         case (op)
            stld_pkg::OP_OR:   pels[idx] = prev | color;
            stld_pkg::OP_XOR:  pels[idx] = prev ^ color;
            default: pels[idx] = color;
         endcase
      endfunction

      function void trace_line(int x0, int y0, int x1, int y1, bit styled);
         int dx, dy, sx, sy, err, e2, along, w;
         dx = (x1 > x0) ? x1 - x0 : x0 - x1;
         dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
         sx = (x0 < x1) ? 1 : -1;
         sy = (y0 < y1) ? 1 : -1;
         err = dx + dy;
         along = 0;
         w = weight[1] ? 2 : 1;
         forever begin
            if (!styled || step_visible(along))
               for (int wy = 0; wy < w; wy++)
                  for (int wx = 0; wx < w; wx++)
                     stamp(x0 + wx, y0 + wy);
            if (x0 == x1 && y0 == y1) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
               err += dy;
               x0 += sx;
            end
            if (e2 <= dx) begin
               err += dx;
               y0 += sy;
            end
            along++;
         end
      endfunction

      function void note_request(bit mode, int sx, int sy, int ex, int ey, bit styled);
         if (mode) begin
            want_value.push_back((sx < PW && sy < PH) ? pels[sy*PW + sx] : 3'd0);
            want_done.push_back(1'b0);
         end else begin
            trace_line(sx, sy, ex, ey, styled);
            want_value.push_back(3'd0);
            want_done.push_back(1'b1);
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(bit [2:0] value, bit done);
         if (want_value.size() == 0) begin
            report_mismatch("unexpected response, draw_done", done, -1);
            return;
         end
         if (value != want_value[0]) report_mismatch("read_value", value, want_value[0]);
         if (done != want_done[0]) report_mismatch("draw_done", done, want_done[0]);
         void'(want_value.pop_front());
         void'(want_done.pop_front());
      endtask

      function int pending();
         return want_value.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_mode = 1'b0;
   logic [8:0] req_start_x = '0;
   logic [8:0] req_start_y = '0;
   logic [8:0] req_end_x = '0;
   logic [8:0] req_end_y = '0;
   logic       req_use_dash = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_read_value;
   logic       rsp_draw_done;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_index = '0;
   logic [5:0] csr_data = '0;

   line_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int last_x = 0, last_y = 0;

   styled_thick_line_draw_unit dut (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_read_value, rsp_draw_done);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task write_csr(bit [3:0] idx, bit [5:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   task send_request(bit mode, int sx, int sy, int ex, int ey, bit styled);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      req_use_dash <= styled;
      do @(posedge clock); while (!req_ready);
      sb.note_request(mode, sx, sy, ex, ey, styled);
      if (!mode) begin
         last_x = ex;
         last_y = ey;
      end
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function int near(int c, int span);
      int v;
      v = c + $urandom_range(0, 2*span) - span;
      return (v < 0) ? 0 : (v > 511 ? 511 : v);
   endfunction

   task random_request();
      int sx, sy, ex, ey;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         // Mostly read back around the last line so stored pels are seen.
         if ($urandom_range(0, 3) != 0) begin
            sx = near(last_x, 2);
            sy = near(last_y, 2);
         end else begin
            sx = $urandom_range(0, 511);
            sy = $urandom_range(0, 511);
         end
         send_request(1'b1, sx, sy, $urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 1));
      end else begin
         if (pick < 30) begin
            sx = $urandom_range(0, 511);
            sy = $urandom_range(0, 511);
            ex = $urandom_range(0, 511);
            ey = $urandom_range(0, 511);
         end else begin
            sx = (pick < 40) ? $urandom_range(0, 511) : $urandom_range(0, PW - 1);
            sy = (pick < 40) ? $urandom_range(0, 511) : $urandom_range(0, PH - 1);
            ex = near(sx, 24);
            ey = near(sy, 24);
         end
         send_request(1'b0, sx, sy, ex, ey, $urandom_range(0, 1));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: solid single pels, replace.
      send_request(1'b1, 0, 0, 0, 0, 1'b0);
      send_request(1'b0, 0, 0, 479, 287, 1'b0);
      send_request(1'b1, 479, 287, 0, 0, 1'b0);
      send_request(1'b0, 470, 280, 511, 511, 1'b1);
      send_request(1'b1, 511, 511, 511, 511, 1'b1);
      send_request(1'b1, 480, 0, 0, 0, 1'b0);
      send_request(1'b0, 10, 10, 10, 10, 1'b0);
      send_request(1'b0, 300, 5, 3, 5, 1'b1);
      send_request(1'b1, 100, 5, 0, 0, 1'b0);
      drain();

      // Odd codes: weight 0 and 3, combine code 3, full dash runs, stray index.
      write_csr(stld_pkg::REG_PEN_WEIGHT, 6'd3);
      write_csr(stld_pkg::REG_COMBINE, 6'd3);
      write_csr(stld_pkg::REG_PEN_COLOR, 6'd5);
      write_csr(stld_pkg::REG_DASH_ON0, 6'd63);
      write_csr(stld_pkg::REG_DASH_OFF0, 6'd63);
      write_csr(stld_pkg::REG_DASH_ON1, 6'd63);
      write_csr(stld_pkg::REG_DASH_OFF1, 6'd63);
      write_csr(stld_pkg::REG_DASH_START, 6'd63);
      write_csr(4'd8, 6'd63);
      write_csr(4'd15, 6'd0);
      send_request(1'b0, 479, 287, 479, 0, 1'b1);
      send_request(1'b1, 479, 100, 0, 0, 1'b0);
      send_request(1'b0, 0, 200, 300, 200, 1'b1);
      send_request(1'b1, 20, 200, 0, 0, 1'b0);
      drain();
      write_csr(stld_pkg::REG_PEN_WEIGHT, 6'd0);
      write_csr(stld_pkg::REG_DASH_START, 6'd0);
      write_csr(stld_pkg::REG_DASH_ON0, 6'd1);
      write_csr(stld_pkg::REG_DASH_OFF0, 6'd0);
      send_request(1'b0, 5, 250, 60, 270, 1'b1);
      send_request(1'b1, 5, 250, 0, 0, 1'b0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         write_csr(stld_pkg::REG_PEN_COLOR, $urandom_range(0, 7));
         write_csr(stld_pkg::REG_PEN_WEIGHT, $urandom_range(0, 3));
         write_csr(stld_pkg::REG_COMBINE, $urandom_range(0, 3));
         write_csr(stld_pkg::REG_DASH_ON0, (phase == 0) ? 6'd63 : $urandom_range(0, 7));
         write_csr(stld_pkg::REG_DASH_OFF0, (phase == 1) ? 6'd0 : $urandom_range(0, 7));
         write_csr(stld_pkg::REG_DASH_ON1, $urandom_range(0, 7));
         write_csr(stld_pkg::REG_DASH_OFF1, $urandom_range(0, 7));
         write_csr(stld_pkg::REG_DASH_START, $urandom_range(0, 63));
         write_csr($urandom_range(8, 15), $urandom_range(0, 63));
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         // Starve the response side for a while so the request side backs up.
         if (phase == 4) hold_left = 3000;
         repeat (36) random_request();
         drain();
      end

      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- styled_thick_line_draw_unit.f -----
src/stld_pkg.sv
src/stld_ram.sv
src/stld_dash.sv
src/styled_thick_line_draw_unit.sv
tb/tb_styled_thick_line_draw_unit.sv
